/* rtl/isq_pkg.sv */
// ----------------------------------------------------------------------------
// isq_pkg: shared definitions for the interval selection query block
// Default sizes, opcode codes and result constants.
// ----------------------------------------------------------------------------
package isq_pkg;

  // default configuration
  localparam int unsigned DEF_MAX_INTERVALS = 1024;
  localparam int unsigned DEF_COORD_BITS    = 30;

  // item opcodes
  localparam int unsigned OPCODE_W = 2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  // chosen count, saturating
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

/* rtl/isq_ram.sv */
// ----------------------------------------------------------------------------
// isq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module isq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/interval_selection_query_top.sv */
// ----------------------------------------------------------------------------
// interval_selection_query_top: greedy interval selection over a sorted store
// Holds intervals sorted by end in one RAM and answers selection queries.
// ----------------------------------------------------------------------------
// Operation: one item at a time; in_ready_o is high only while the sequencer
// is idle. A clear, an unused opcode or a load into a full store goes
// straight to the done state. A load moves each stored interval with a
// larger end up one slot and stops at a stored interval with a smaller or
// equal end, or at slot zero (an empty store included). A query walks the
// set in end order and stops at an interval that starts at or after the
// running low but ends past the window, or when it runs off the end of the
// set. Each stored entry takes a read state, which presents the address to
// the interval RAM, whose read data is registered, and a compare state for
// the compare and the update. A finished result sits in the output
// register; the next item is accepted while it waits, and the sequencer
// holds the following result until the output register is free. The
// interval RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module interval_selection_query_top #(
  parameter int unsigned MAX_INTERVALS = isq_pkg::DEF_MAX_INTERVALS,
  parameter int unsigned COORD_BITS    = isq_pkg::DEF_COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [isq_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [COORD_BITS-1:0]         interval_begin_i,
  input  logic [COORD_BITS-1:0]         interval_end_i,
  input  logic [COORD_BITS-1:0]         query_low_i,
  input  logic [COORD_BITS-1:0]         query_high_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [isq_pkg::COUNT_W-1:0]   chosen_count_o,
  output logic                          load_dropped_o
);

  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned HW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned EW = 2 * COORD_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LD_RD  = 3'd1;
  localparam logic [2:0] ST_LD_CMP = 3'd2;
  localparam logic [2:0] ST_Q_RD   = 3'd3;
  localparam logic [2:0] ST_Q_CMP  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [HW-1:0]               held_q, held_d;
  logic [HW-1:0]               pos_q, pos_d;     // insert slot or walk index
  logic [COORD_BITS-1:0]       arg_a_q, arg_a_d; // begin of load / running low
  logic [COORD_BITS-1:0]       arg_b_q, arg_b_d; // end of load / query high
  logic [isq_pkg::COUNT_W-1:0] count_q, count_d;
  logic                        dropped_q, dropped_d;
  logic                        out_valid_q, out_valid_d;
  logic [isq_pkg::COUNT_W-1:0] out_count_q, out_count_d;
  logic                        out_dropped_q, out_dropped_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [EW-1:0]               ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [EW-1:0]               ram_rdata;
  logic [COORD_BITS-1:0]       rd_begin;
  logic [COORD_BITS-1:0]       rd_end;
  logic [HW-1:0]               pos_dec;
  logic                        in_xfer;
  logic                        out_free;

  // interval store: {begin, end} per entry, sorted by end
  isq_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_INTERVALS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_begin = ram_rdata[EW-1:COORD_BITS];
  assign rd_end   = ram_rdata[COORD_BITS-1:0];
  assign pos_dec  = pos_q - HW'(1);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d       = state_q;
    held_d        = held_q;
    pos_d         = pos_q;
    arg_a_d       = arg_a_q;
    arg_b_d       = arg_b_q;
    count_d       = count_q;
    dropped_d     = dropped_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_count_d   = out_count_q;
    out_dropped_d = out_dropped_q;
    ram_we        = 1'b0;
    ram_waddr     = pos_q[AW-1:0];
    ram_wdata     = {arg_a_q, arg_b_q};
    ram_raddr     = pos_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          count_d   = '0;
          dropped_d = 1'b0;
          case (opcode_i)
            isq_pkg::OP_CLEAR: begin
              held_d  = '0;
              state_d = ST_DONE;
            end
            isq_pkg::OP_LOAD: begin
              arg_a_d = interval_begin_i;
              arg_b_d = interval_end_i;
              pos_d   = held_q;
              if (held_q == HW'(MAX_INTERVALS)) begin
                dropped_d = 1'b1;
                state_d   = ST_DONE;
              end else begin
                state_d = ST_LD_RD;
              end
            end
            isq_pkg::OP_QUERY: begin
              arg_a_d = query_low_i;
              arg_b_d = query_high_i;
              pos_d   = '0;
              state_d = ST_Q_RD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // look at the entry just below the insert slot
      ST_LD_RD: begin
        ram_raddr = pos_dec[AW-1:0];
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          held_d  = held_q + HW'(1);
          state_d = ST_DONE;
        end else begin
          state_d = ST_LD_CMP;
        end
      end

      // move a larger end up one slot, or drop the new interval in
      ST_LD_CMP: begin
        ram_we = 1'b1;
        if (rd_end > arg_b_q) begin
          ram_wdata = ram_rdata;
          pos_d     = pos_dec;
          state_d   = ST_LD_RD;
        end else begin
          held_d  = held_q + HW'(1);
          state_d = ST_DONE;
        end
      end

      // fetch the next entry in end order
      ST_Q_RD: begin
        if (pos_q == held_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_Q_CMP;
        end
      end

      // greedy pick step
      ST_Q_CMP: begin
        if (rd_begin >= arg_a_q) begin
          if (rd_end <= arg_b_q) begin
            if (count_q != isq_pkg::COUNT_MAX) begin
              count_d = count_q + isq_pkg::COUNT_W'(1);
            end
            arg_a_d = rd_end;
            pos_d   = pos_q + HW'(1);
            state_d = ST_Q_RD;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          pos_d   = pos_q + HW'(1);
          state_d = ST_Q_RD;
        end
      end

      // hand the result to the output register
      ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_count_d   = count_q;
          out_dropped_d = dropped_q;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    arg_a_q       <= arg_a_d;
    arg_b_q       <= arg_b_d;
    count_q       <= count_d;
    dropped_q     <= dropped_d;
    out_count_q   <= out_count_d;
    out_dropped_q <= out_dropped_d;
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_count_o = out_count_q;
  assign load_dropped_o = out_dropped_q;

  // checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HW'(MAX_INTERVALS))
    else $error("held count above capacity");

  a_write_only_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_LD_RD || state_q == ST_LD_CMP))
    else $error("store written outside a load");

  a_held_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != $past(held_q)) |-> (held_q == '0 || held_q == $past(held_q) + HW'(1)))
    else $error("held count moved by more than one");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_RD || state_q == ST_Q_CMP) |-> pos_q <= held_q)
    else $error("query walk past the stored set");

  a_drop_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && load_dropped_o) |-> chosen_count_o == '0)
    else $error("dropped load reported a count");

endmodule
